// ===== design/assert_macros.svh =====
// Assertion macros shared by the digit emitter modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// ===== design/srde_pkg.sv =====
// Shared constants, types and helper functions of the signed radix digit emitter.
// Depends on nothing; imported by every module of the block.
package srde_pkg;

  localparam int WORD_W          = 32;
  localparam int SYM_W           = 8;
  localparam int RADIX_W         = 5;
  localparam int DIGIT_W         = 4;
  localparam int MAX_RADIX       = 16;
  localparam int NUM_SYMBOLS     = 16;
  localparam int MAX_DIGITS      = 32;
  localparam int DIGIT_IDX_W     = 5;
  localparam int DIGIT_CNT_W     = 6;
  localparam int BITS_PER_STEP   = 8;
  localparam int STEPS_PER_DIGIT = WORD_W / BITS_PER_STEP;
  localparam int STEP_W          = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_W     = 1;
  localparam int QUEUE_CNT_W     = 2;

  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  typedef struct packed {
    logic              neg;
    logic [WORD_W-1:0] mag;
  } srde_word_t;

  typedef struct packed {
    logic                                alphabet_ok;
    logic [RADIX_W-1:0]                  radix;
    logic [NUM_SYMBOLS-1:0][SYM_W-1:0]   symbols;
  } srde_cfg_t;

  function automatic logic [SYM_W-1:0] symbol_at(
    input logic [NUM_SYMBOLS-1:0][SYM_W-1:0] symbols,
    input logic [DIGIT_W-1:0]                digit
  );
    return symbols[digit];
  endfunction

endpackage

// ===== design/srde_cfg.sv =====
// Configuration registers and registered alphabet validity check.
// Depends on srde_pkg.
module srde_cfg import srde_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output srde_cfg_t             cfg
);

  logic [RADIX_W-1:0]                radix_len;
  logic [CFG_DATA_W-1:0]             symbols_low;
  logic [CFG_DATA_W-1:0]             symbols_high;
  logic                              alphabet_ok;
  logic                              alphabet_ok_next;
  logic [NUM_SYMBOLS-1:0][SYM_W-1:0] symbols;

  assign symbols = {symbols_high, symbols_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_len    <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
      alphabet_ok  <= 1'b0;
    end else begin
      alphabet_ok <= alphabet_ok_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RADIX_LEN:    radix_len    <= cfg_data[RADIX_W-1:0];
          CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
          CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    alphabet_ok_next = (radix_len >= RADIX_W'(2)) && (radix_len <= RADIX_W'(MAX_RADIX));
    for (int a = 0; a < NUM_SYMBOLS; a++) begin
      if (RADIX_W'(a) < radix_len) begin
        if (symbols[a] == '0 || symbols[a] == CHAR_PLUS || symbols[a] == CHAR_MINUS) begin
          alphabet_ok_next = 1'b0;
        end
        for (int b = a + 1; b < NUM_SYMBOLS; b++) begin
          if (RADIX_W'(b) < radix_len && symbols[b] == symbols[a]) begin
            alphabet_ok_next = 1'b0;
          end
        end
      end
    end
  end

  assign cfg.alphabet_ok = alphabet_ok;
  assign cfg.radix       = radix_len;
  assign cfg.symbols     = symbols;

endmodule

// ===== design/srde_front.sv =====
// Input stage: accepts a number and splits it into sign and magnitude.
// Depends on srde_pkg.
module srde_front import srde_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] number,
  output logic              push,
  output srde_word_t        push_word,
  input  logic              queue_full
);

  logic       front_valid;
  srde_word_t front_word;
  logic       accept;

  assign push     = front_valid && !queue_full;
  assign in_stall = front_valid && queue_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  // The most negative value negates to itself, which is its correct magnitude.
  always_ff @(posedge clk) begin
    if (accept) begin
      front_word.neg <= number[WORD_W-1];
      front_word.mag <= number[WORD_W-1] ? (WORD_W'(0) - number) : number;
    end
  end

  assign push_word = front_word;

endmodule

// ===== design/srde_queue.sv =====
// Short word queue between the input stage and the digit engine.
// Depends on srde_pkg and assert_macros.svh.
`include "assert_macros.svh"
module srde_queue import srde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  srde_word_t push_word,
  output logic       full,
  input  logic       pop,
  output srde_word_t pop_word,
  output logic       empty
);

  srde_word_t             words [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  assign full     = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = words[rd_ptr];

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop) count <= count + QUEUE_CNT_W'(1);
      else if (do_pop && !do_push) count <= count - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) words[wr_ptr] <= push_word;
  end

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= QUEUE_CNT_W'(QUEUE_DEPTH))
  `ASSERT_NEXT(a_push_fills, clk, rst, do_push && !do_pop, !empty)
  `ASSERT_NEXT(a_pop_frees, clk, rst, do_pop && !do_push, !full)

endmodule

// ===== design/srde_back.sv =====
// Digit engine: divides by the radix eight bits a cycle, stores digits, emits symbols.
// Depends on srde_pkg and assert_macros.svh.
`include "assert_macros.svh"
module srde_back import srde_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  srde_cfg_t        cfg,
  input  logic             queue_empty,
  input  srde_word_t       pop_word,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SYM_W-1:0] symbol,
  output logic             final_symbol,
  output logic             bad_alphabet
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_SIGN = 5'b00100,
    S_EMIT = 5'b01000,
    S_BAD  = 5'b10000
  } back_state_t;

  back_state_t              state;
  logic [WORD_W-1:0]        dividend;
  logic [DIGIT_W-1:0]       rem;
  logic [STEP_W-1:0]        step;
  logic                     neg;
  logic [DIGIT_CNT_W-1:0]   nd;
  logic [DIGIT_W-1:0]       digits [MAX_DIGITS];
  logic [WORD_W-1:0]        quotient_next;
  logic [DIGIT_W-1:0]       rem_next;
  logic [BITS_PER_STEP-1:0] qbits;
  logic [RADIX_W-1:0]       r;
  logic                     load;
  logic [DIGIT_IDX_W-1:0]   emit_idx;

  assign load     = !out_valid || !out_stall;
  assign pop      = (state == S_IDLE) && !queue_empty;
  assign emit_idx = DIGIT_IDX_W'(nd - DIGIT_CNT_W'(1));

  always_comb begin
    r = {1'b0, rem};
    qbits = '0;
    for (int j = 0; j < BITS_PER_STEP; j++) begin
      r = {r[RADIX_W-2:0], dividend[WORD_W-1-j]};
      qbits[BITS_PER_STEP-1-j] = (r >= cfg.radix);
      if (r >= cfg.radix) r = r - cfg.radix;
    end
    rem_next      = r[DIGIT_W-1:0];
    quotient_next = {dividend[WORD_W-BITS_PER_STEP-1:0], qbits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= (state inside {S_SIGN, S_EMIT, S_BAD});
      case (state)
        S_IDLE: begin
          if (!queue_empty) state <= cfg.alphabet_ok ? S_DIV : S_BAD;
        end
        S_DIV: begin
          if (step == STEP_W'(STEPS_PER_DIGIT - 1) &&
              (quotient_next == '0 || nd == DIGIT_CNT_W'(MAX_DIGITS - 1))) begin
            state <= neg ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (load) state <= S_EMIT;
        end
        S_EMIT: begin
          if (load && nd == DIGIT_CNT_W'(1)) state <= S_IDLE;
        end
        S_BAD: begin
          if (load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        dividend <= pop_word.mag;
        neg      <= pop_word.neg;
        rem      <= '0;
        step     <= '0;
        nd       <= '0;
      end
      S_DIV: begin
        dividend <= quotient_next;
        step     <= step + STEP_W'(1);
        if (step == STEP_W'(STEPS_PER_DIGIT - 1)) begin
          digits[nd[DIGIT_IDX_W-1:0]] <= rem_next;
          nd  <= nd + DIGIT_CNT_W'(1);
          rem <= '0;
        end else begin
          rem <= rem_next;
        end
      end
      S_SIGN: begin
        if (load) begin
          symbol       <= CHAR_MINUS;
          final_symbol <= 1'b0;
          bad_alphabet <= 1'b0;
        end
      end
      S_EMIT: begin
        if (load) begin
          symbol       <= symbol_at(cfg.symbols, digits[emit_idx]);
          final_symbol <= (nd == DIGIT_CNT_W'(1));
          bad_alphabet <= 1'b0;
          nd           <= nd - DIGIT_CNT_W'(1);
        end
      end
      S_BAD: begin
        if (load) begin
          symbol       <= '0;
          final_symbol <= 1'b1;
          bad_alphabet <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMPLIES(a_bad_is_final, clk, rst, out_valid && bad_alphabet, final_symbol)
  `ASSERT_IMPLIES(a_emit_has_digits, clk, rst, state == S_EMIT, nd != '0)
  `ASSERT_IMPLIES(a_digit_bound, clk, rst, 1'b1, nd <= DIGIT_CNT_W'(MAX_DIGITS))

endmodule

// ===== design/signed_radix_digit_emitter_core.sv =====
// Top level of the signed radix digit emitter: configuration, input stage, queue, digit engine.
// Depends on srde_pkg, srde_cfg, srde_front, srde_queue and srde_back.
//
//   Channel  Handshake               Payload
//   -------  ----------------------  ------------------------------------------
//   in       in_valid / in_stall     number (32-bit signed)
//   out      out_valid / out_stall   symbol, final_symbol, bad_alphabet
//   cfg      cfg_we                  cfg_index, cfg_data (64 bits)
//
// Each digit takes STEPS_PER_DIGIT division steps; the symbols then go out one at a time.
// The digit engine's division yields eight quotient bits per cycle.
// An invalid alphabet gives a single word from the bad state after a pop, unless stalled.
// Reset zeroes the configuration registers, which makes the alphabet invalid until written.
// A stalled output holds its word; input stage and queue take numbers until both fill.
module signed_radix_digit_emitter_core import srde_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WORD_W-1:0]     number,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SYM_W-1:0]      symbol,
  output logic                  final_symbol,
  output logic                  bad_alphabet
);

  srde_cfg_t  cfg;
  logic       push;
  srde_word_t push_word;
  logic       queue_full;
  logic       queue_empty;
  logic       pop;
  srde_word_t pop_word;

  srde_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srde_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .number     (number),
    .push       (push),
    .push_word  (push_word),
    .queue_full (queue_full)
  );

  srde_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (queue_full),
    .pop       (pop),
    .pop_word  (pop_word),
    .empty     (queue_empty)
  );

  srde_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .queue_empty  (queue_empty),
    .pop_word     (pop_word),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol       (symbol),
    .final_symbol (final_symbol),
    .bad_alphabet (bad_alphabet)
  );

endmodule
